[hdl/arss_pkg.sv]
// ---------------------------------------------------------------------------
// arss_pkg
// Shared widths, reset values, codes and types of the sample scaler.
// ---------------------------------------------------------------------------
package arss_pkg;

   // field widths
   localparam int SAMPLE_W   = 12;
   localparam int TARGET_W   = 10;
   localparam int PROD_W     = SAMPLE_W + TARGET_W;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // defaults handed to the top level parameters
   localparam int BLOCK_SAMPLES_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   // reset values
   localparam logic [SAMPLE_W-1:0]        FULL_SCALE        = '1;
   localparam logic signed [TARGET_W-1:0] TARGET_LOW_RESET  = -10'sd40;
   localparam logic signed [TARGET_W-1:0] TARGET_HIGH_RESET = 10'sd140;

   // input opcodes
   typedef enum logic {
      OP_SAMPLE      = 1'b0,
      OP_RANGE_CLEAR = 1'b1
   } opcode_type;

   // register indexes
   typedef enum logic {
      REG_TARGET_LOW  = 1'b0,
      REG_TARGET_HIGH = 1'b1
   } reg_index_type;

   // work handed from the front to the back
   typedef enum logic {
      TASK_BLOCK = 1'b0,
      TASK_CLEAR = 1'b1
   } task_kind_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[hdl/arss_if.sv]
// ---------------------------------------------------------------------------
// arss_req_if / arss_rsp_if
// Valid/ready channels for raw samples in and scaled results out.
// ---------------------------------------------------------------------------
interface arss_req_if;
   import arss_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, opcode, sample, input ready);
   modport sink   (input valid, opcode, sample, output ready);
endinterface

interface arss_rsp_if;
   import arss_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [SAMPLE_W-1:0]        average;
   logic [SAMPLE_W-1:0]        lowest_seen;
   logic [SAMPLE_W-1:0]        highest_seen;
   logic signed [TARGET_W-1:0] scaled;

   modport source (output valid, average, lowest_seen, highest_seen, scaled, input ready);
   modport sink   (input valid, average, lowest_seen, highest_seen, scaled, output ready);
endinterface

[hdl/arss_divider.sv]
// ---------------------------------------------------------------------------
// arss_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module arss_divider #(
   parameter int DVD_W = arss_pkg::PROD_W,
   parameter int DVS_W = arss_pkg::SAMPLE_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   import arss_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   // trial subtract of the shifted remainder
   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = (trial >= {1'b0, dvs_ff});

   // step control
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = CNT_W'(DVD_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DVD_W-2:0], fits};
         rem_in   = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/arss_queue.sv]
// ---------------------------------------------------------------------------
// arss_queue
// Short register queue between the front and the back.
// ---------------------------------------------------------------------------
module arss_queue #(
   parameter int W     = 17,
   parameter int DEPTH = arss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [W-1:0]               push_data,
   input  logic                       pop,
   output logic [W-1:0]               head,
   output arss_pkg::queue_status_type status
);
   import arss_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);

endmodule

[hdl/arss_front.sv]
// ---------------------------------------------------------------------------
// arss_front
// Takes input transactions, sums sample blocks and queues block or clear work.
// ---------------------------------------------------------------------------
module arss_front #(
   parameter int BLOCK_SAMPLES = arss_pkg::BLOCK_SAMPLES_DEFAULT,
   parameter int SUM_W         = arss_pkg::SAMPLE_W + 4
) (
   input  logic                       clock,
   input  logic                       reset,
   arss_req_if.sink                   req_chan,
   input  arss_pkg::queue_status_type q_status,
   output logic                       q_push,
   output logic [SUM_W:0]             q_data
);
   import arss_pkg::*;

   localparam int CNT_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             last;
   logic [SUM_W-1:0] sum_next;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign last           = (count_ff == CNT_W'(BLOCK_SAMPLES - 1));
   assign sum_next       = sum_ff + SUM_W'(req_chan.sample);

   // classify the transaction
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      q_push   = 1'b0;
      q_data   = {TASK_BLOCK, sum_next};
      if (accept) begin
         if (req_chan.opcode == OP_RANGE_CLEAR) begin
            q_push = 1'b1;
            q_data = {TASK_CLEAR, sum_next};
         end else if (last) begin
            q_push   = 1'b1;
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

[hdl/arss_back.sv]
// ---------------------------------------------------------------------------
// arss_back
// Forms block means, tracks min/max and maps the mean onto the target range.
// ---------------------------------------------------------------------------
module arss_back #(
   parameter int BLOCK_SAMPLES = arss_pkg::BLOCK_SAMPLES_DEFAULT,
   parameter int SUM_W         = arss_pkg::SAMPLE_W + 4,
   parameter int DVD_W         = arss_pkg::PROD_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  arss_pkg::queue_status_type           q_status,
   input  logic [SUM_W:0]                       q_head,
   output logic                                 q_pop,
   input  logic signed [arss_pkg::TARGET_W-1:0] target_low,
   input  logic signed [arss_pkg::TARGET_W-1:0] target_high,
   arss_rsp_if.source                           rsp_chan
);
   import arss_pkg::*;

   // reciprocal of the block length, exact floor for every sum below 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + $clog2(BLOCK_SAMPLES);
   localparam int RECIP_W     = SUM_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << RECIP_SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MEAN  = 5'b00010,
      ST_MAP   = 5'b00100,
      ST_SCALE = 5'b01000,
      ST_SEND  = 5'b10000
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [SAMPLE_W-1:0]        range_low_ff, range_low_in;
   logic [SAMPLE_W-1:0]        range_high_ff, range_high_in;
   logic [SAMPLE_W-1:0]        mean_ff, mean_in;
   logic signed [TARGET_W-1:0] scaled_ff, scaled_in;
   logic                       out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]        out_avg_ff, out_low_ff, out_high_ff;
   logic signed [TARGET_W-1:0] out_scaled_ff;
   logic                       out_load;

   task_kind_type              head_kind;
   logic [SUM_W-1:0]           head_sum;
   logic [SUM_W+RECIP_W-1:0]   mean_prod;
   logic [SAMPLE_W-1:0]        mean_q;
   logic                       has_span;
   logic [SAMPLE_W-1:0]        clamped;
   logic [SAMPLE_W-1:0]        offset;
   logic [SAMPLE_W-1:0]        span;
   logic [TARGET_W:0]          diff;
   logic [TARGET_W:0]          diff_abs;
   logic                       diff_neg;
   logic [PROD_W-1:0]          product;
   logic [TARGET_W:0]          quo_signed;
   logic [TARGET_W:0]          scaled_sum;

   logic                       div_start;
   logic [DVD_W-1:0]           div_dividend;
   logic [SAMPLE_W-1:0]        div_divisor;
   logic                       div_done;
   logic [DVD_W-1:0]           div_quotient;

   assign head_kind = task_kind_type'(q_head[SUM_W]);
   assign head_sum  = q_head[SUM_W-1:0];

   // block mean by reciprocal multiplication
   assign mean_prod = {{RECIP_W{1'b0}}, head_sum} * {{SUM_W{1'b0}}, RECIP};
   assign mean_q    = mean_prod[RECIP_SHIFT +: SAMPLE_W];

   // linear map datapath
   assign has_span = (range_high_ff > range_low_ff);
   assign clamped  = (mean_ff < range_low_ff)  ? range_low_ff  :
                     (mean_ff > range_high_ff) ? range_high_ff : mean_ff;
   assign offset   = clamped - range_low_ff;
   assign span     = range_high_ff - range_low_ff;
   assign diff     = {target_high[TARGET_W-1], target_high}
                   - {target_low[TARGET_W-1], target_low};
   assign diff_neg = diff[TARGET_W];
   assign diff_abs = diff_neg ? (~diff + (TARGET_W+1)'(1)) : diff;
   assign product  = {{TARGET_W{1'b0}}, offset} * {{SAMPLE_W{1'b0}}, diff_abs[TARGET_W-1:0]};

   // signed quotient added to the low target
   assign quo_signed = diff_neg ? (~{1'b0, div_quotient[TARGET_W-1:0]} + (TARGET_W+1)'(1))
                                : {1'b0, div_quotient[TARGET_W-1:0]};
   assign scaled_sum = {target_low[TARGET_W-1], target_low} + quo_signed;

   // divider operands for the map
   assign div_dividend = DVD_W'(product);
   assign div_divisor  = span;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      mean_in       = mean_ff;
      scaled_in     = scaled_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (head_kind == TASK_CLEAR) begin
                  range_low_in  = FULL_SCALE;
                  range_high_in = '0;
               end else begin
                  mean_in  = mean_q;
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (mean_ff < range_low_ff) begin
               range_low_in = mean_ff;
            end
            if (mean_ff > range_high_ff) begin
               range_high_in = mean_ff;
            end
            state_in = ST_MAP;
         end
         ST_MAP: begin
            if (has_span) begin
               div_start = 1'b1;
               state_in  = ST_SCALE;
            end else begin
               scaled_in = target_low;
               state_in  = ST_SEND;
            end
         end
         ST_SCALE: begin
            if (div_done) begin
               scaled_in = scaled_sum[TARGET_W-1:0];
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         range_low_ff  <= FULL_SCALE;
         range_high_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mean_ff   <= mean_in;
      scaled_ff <= scaled_in;
      if (out_load) begin
         out_avg_ff    <= mean_ff;
         out_low_ff    <= range_low_ff;
         out_high_ff   <= range_high_ff;
         out_scaled_ff <= scaled_ff;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.average      = out_avg_ff;
   assign rsp_chan.lowest_seen  = out_low_ff;
   assign rsp_chan.highest_seen = out_high_ff;
   assign rsp_chan.scaled       = out_scaled_ff;

   arss_divider #(
      .DVD_W (DVD_W),
      .DVS_W (SAMPLE_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

[hdl/auto_range_sample_scaler.sv]
// ---------------------------------------------------------------------------
// auto_range_sample_scaler
// Block averaging of converter samples with min/max auto-range and a linear
// map of each block mean onto a programmable target range.
// ---------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  req_chan  in         valid/ready     opcode, sample
//  rsp_chan  out        valid/ready     average, lowest_seen, highest_seen, scaled
//  csr_*     in/out     apb write/read  target_low @0x0, target_high @0x4
//
//  a sample or range clear transaction is taken by the front
//  a finished block steps the back through its mean, map, scale and send
//  states, with one pass through the one-bit-per-cycle divider for the map;
//  an empty or single-point range skips the divider and the scale state
//  a two-entry queue lets the front keep taking transactions meanwhile;
//  req ready drops only while the queue is full, a stalled result holds the back
//  synchronous active-high reset; no clearing pass
// ---------------------------------------------------------------------------
module auto_range_sample_scaler #(
   parameter int BLOCK_SAMPLES = arss_pkg::BLOCK_SAMPLES_DEFAULT,
   parameter int QUEUE_DEPTH   = arss_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   arss_req_if.sink                         req_chan,
   arss_rsp_if.source                       rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [arss_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [arss_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [arss_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import arss_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(BLOCK_SAMPLES);
   localparam int DVD_W = PROD_W;

   logic signed [TARGET_W-1:0] target_low_ff, target_low_in;
   logic signed [TARGET_W-1:0] target_high_ff, target_high_in;
   logic                       csr_write;
   reg_index_type              csr_index;

   queue_status_type           q_status;
   logic                       q_push;
   logic                       q_pop;
   logic [SUM_W:0]             q_data;
   logic [SUM_W:0]             q_head;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      target_low_in  = target_low_ff;
      target_high_in = target_high_ff;
      csr_prdata     = '0;
      unique case (csr_index)
         REG_TARGET_LOW: begin
            csr_prdata = CSR_DATA_W'(target_low_ff);
            if (csr_write) begin
               target_low_in = csr_pwdata[TARGET_W-1:0];
            end
         end
         REG_TARGET_HIGH: begin
            csr_prdata = CSR_DATA_W'(target_high_ff);
            if (csr_write) begin
               target_high_in = csr_pwdata[TARGET_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_low_ff  <= TARGET_LOW_RESET;
         target_high_ff <= TARGET_HIGH_RESET;
      end else begin
         target_low_ff  <= target_low_in;
         target_high_ff <= target_high_in;
      end
   end

   arss_front #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .SUM_W         (SUM_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   arss_queue #(
      .W     (SUM_W + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   arss_back #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .SUM_W         (SUM_W),
      .DVD_W         (DVD_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .target_low  (target_low_ff),
      .target_high (target_high_ff),
      .rsp_chan    (rsp_chan)
   );

   // front never writes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue push while full");

   // back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue pop while empty");

   // a reported mean lies inside the reported range
   a_mean_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.lowest_seen <= rsp_chan.average &&
                          rsp_chan.average <= rsp_chan.highest_seen))
      else $error("average outside observed range");

   // mapped value lies between the two targets
   a_scaled_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         ((rsp_chan.scaled >= target_low_ff && rsp_chan.scaled <= target_high_ff) ||
          (rsp_chan.scaled <= target_low_ff && rsp_chan.scaled >= target_high_ff)))
      else $error("scaled value outside target range");

endmodule
